// ===== design/tcag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcag_pkg
// Shared types, constants and helpers of the toroidal cellular automaton grid.
// ----------------------------------------------------------------------------
package tcag_pkg;

   localparam int COLS        = 64;
   localparam int ROWS        = 64;
   localparam int CELL_COUNT  = COLS * ROWS;
   localparam int XW          = $clog2(COLS);
   localparam int YW          = $clog2(ROWS);
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int STEP_W      = 4;

   // actions
   localparam logic [1:0] ACT_WRITE    = 2'd0;
   localparam logic [1:0] ACT_READ     = 2'd1;
   localparam logic [1:0] ACT_LIFE     = 2'd2;
   localparam logic [1:0] ACT_MARGOLUS = 2'd3;

   // datapath operations
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_CLEAR    = 3'd1;
   localparam logic [2:0] OP_WRITE    = 3'd2;
   localparam logic [2:0] OP_RD_ISSUE = 3'd3;
   localparam logic [2:0] OP_RD_DONE  = 3'd4;
   localparam logic [2:0] OP_COPY     = 3'd5;
   localparam logic [2:0] OP_LIFE     = 3'd6;
   localparam logic [2:0] OP_MARG     = 3'd7;

   // step numbers of the per-cell and per-block sequences
   localparam logic [STEP_W-1:0] STEP_LAST      = 4'd9;
   localparam logic [STEP_W-1:0] STEP_SELF_DATA = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MARG_SUM  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MARG_WR   = 4'd6;

   typedef struct packed {
      logic [1:0]        action;
      logic signed [7:0] x_coord;
      logic signed [7:0] y_coord;
      logic [7:0]        write_value;
      logic              block_parity;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic [1:0] finished_action;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic [2:0]        op;
      logic [STEP_W-1:0] step;
      logic              finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic copy_done;
      logic cell_last;
      logic block_last;
   } dp_status_type;

   // Reduce a signed byte into 0..size-1 by restoring subtraction.
   function automatic logic [10:0] wrap_coord(input logic signed [7:0] v,
                                              input logic [10:0] size);
      logic [7:0]  mag;
      logic [18:0] rem;
      logic [18:0] sub;
      mag = v[7] ? 8'(-v) : 8'(v);
      rem = 19'(mag);
      for (int k = 7; k >= 0; k--) begin
         sub = 19'(size) << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      if (v[7] && (rem != 19'd0)) begin
         rem = 19'(size) - rem;
      end
      return rem[10:0];
   endfunction

endpackage

// ===== design/tcag_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcag_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcag_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tcag_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcag_dp
// Datapath: grid and snapshot memories, address generation, rule logic.
// ----------------------------------------------------------------------------
module tcag_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  tcag_pkg::req_type       req,
   input  tcag_pkg::ctrl_cmd_type  cmd,
   output tcag_pkg::dp_status_type sts,
   output tcag_pkg::rsp_type       rsp,
   output logic                    rsp_valid
);
   import tcag_pkg::*;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                   input logic [YW-1:0] y);
      return ADDR_W'(y) * ADDR_W'(COLS) + ADDR_W'(x);
   endfunction

   localparam logic [XW-1:0] X_MAX = XW'(COLS - 1);
   localparam logic [YW-1:0] Y_MAX = YW'(ROWS - 1);

   logic [1:0]       act_ff;
   logic [XW-1:0]    wx_ff;
   logic [YW-1:0]    wy_ff;
   logic [7:0]       wval_ff;
   logic             par_ff;
   logic [CNT_W-1:0] lin_ff;
   logic [XW-1:0]    px_ff;
   logic [YW-1:0]    py_ff;
   logic [3:0]       cnt_ff;
   logic             self_ff;
   logic [7:0]       v_ff [4];
   logic             flip_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic [10:0]       wrap_x;
   logic [10:0]       wrap_y;
   logic [XW-1:0]     xl, xr, nbx, mrx, mwx;
   logic [YW-1:0]     yu, yd, nby, mry, mwy;
   logic [1:0]        wsel;
   logic [CNT_W-1:0]  lin_m1;
   logic [XW:0]       next_col;
   logic [YW:0]       next_row;
   logic              col_wrap, row_wrap;
   logic [3:0]        life_sum;
   logic              life_alive;
   logic [9:0]        blk_sum;

   logic              g_we, s_we;
   logic [ADDR_W-1:0] g_waddr, g_raddr, s_waddr, s_raddr;
   logic [7:0]        g_wdata, g_rdata, s_wdata, s_rdata;

   assign wrap_x = wrap_coord(req.x_coord, 11'(COLS));
   assign wrap_y = wrap_coord(req.y_coord, 11'(ROWS));

   assign xl = (px_ff == '0) ? X_MAX : px_ff - XW'(1);
   assign xr = (px_ff == X_MAX) ? '0 : px_ff + XW'(1);
   assign yu = (py_ff == '0) ? Y_MAX : py_ff - YW'(1);
   assign yd = (py_ff == Y_MAX) ? '0 : py_ff + YW'(1);

   // life neighbor k: row k/3, column k%3 of the 3x3 window
   always_comb begin
      case (cmd.step)
         4'd0:    begin nbx = xl;    nby = yu;    end
         4'd1:    begin nbx = px_ff; nby = yu;    end
         4'd2:    begin nbx = xr;    nby = yu;    end
         4'd3:    begin nbx = xl;    nby = py_ff; end
         4'd4:    begin nbx = px_ff; nby = py_ff; end
         4'd5:    begin nbx = xr;    nby = py_ff; end
         4'd6:    begin nbx = xl;    nby = yd;    end
         4'd7:    begin nbx = px_ff; nby = yd;    end
         default: begin nbx = xr;    nby = yd;    end
      endcase
   end

   assign wsel = 2'(cmd.step - STEP_MARG_WR);
   assign mrx  = cmd.step[0] ? xr : px_ff;
   assign mry  = cmd.step[1] ? yd : py_ff;
   assign mwx  = wsel[0] ? xr : px_ff;
   assign mwy  = wsel[1] ? yd : py_ff;

   assign lin_m1 = lin_ff - CNT_W'(1);

   assign life_sum   = cnt_ff + 4'(s_rdata[0]);
   assign life_alive = ((life_sum | 4'(self_ff)) == 4'd3);

   assign blk_sum = 10'(v_ff[0]) + 10'(v_ff[1]) + 10'(v_ff[2]) + 10'(v_ff[3]);

   // next block corner: the wrapping block is followed by the parity start
   assign next_col = (px_ff == X_MAX) ? (XW+1)'(par_ff) : {1'b0, px_ff} + (XW+1)'(2);
   assign next_row = (py_ff == Y_MAX) ? (YW+1)'(par_ff) : {1'b0, py_ff} + (YW+1)'(2);
   assign col_wrap = !(next_col < (XW+1)'(COLS - 1));
   assign row_wrap = !(next_row < (YW+1)'(ROWS - 1));

   assign sts.clear_last = (lin_ff == CNT_W'(CELL_COUNT - 1));
   assign sts.copy_done  = (lin_ff == CNT_W'(CELL_COUNT));
   assign sts.cell_last  = (px_ff == X_MAX) && (py_ff == Y_MAX);
   assign sts.block_last = col_wrap && row_wrap;

   always_comb begin
      g_we    = 1'b0;
      g_waddr = cell_addr(wx_ff, wy_ff);
      g_wdata = 8'd0;
      g_raddr = cell_addr(wx_ff, wy_ff);
      s_we    = 1'b0;
      s_waddr = lin_m1[ADDR_W-1:0];
      s_wdata = g_rdata;
      s_raddr = cell_addr(nbx, nby);
      case (cmd.op)
         OP_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = lin_ff[ADDR_W-1:0];
         end
         OP_WRITE: begin
            g_we    = 1'b1;
            g_wdata = wval_ff;
         end
         OP_COPY: begin
            g_raddr = lin_ff[ADDR_W-1:0];
            s_we    = (lin_ff != '0);
         end
         OP_LIFE: begin
            if (cmd.step == STEP_LAST) begin
               g_we    = 1'b1;
               g_waddr = cell_addr(px_ff, py_ff);
               g_wdata = {6'd0, self_ff, life_alive};
            end
         end
         OP_MARG: begin
            g_raddr = cell_addr(mrx, mry);
            if ((cmd.step >= STEP_MARG_WR) && flip_ff) begin
               g_we    = 1'b1;
               g_waddr = cell_addr(mwx, mwy);
               g_wdata = 8'd1 - v_ff[wsel];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.load) begin
            lin_ff <= '0;
         end else if ((cmd.op == OP_CLEAR) || (cmd.op == OP_COPY)) begin
            lin_ff <= lin_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req.action;
         wx_ff   <= wrap_x[XW-1:0];
         wy_ff   <= wrap_y[YW-1:0];
         wval_ff <= req.write_value;
         par_ff  <= req.block_parity;
         if ((req.action == ACT_MARGOLUS) && req.block_parity) begin
            px_ff <= X_MAX;
            py_ff <= Y_MAX;
         end else begin
            px_ff <= '0;
            py_ff <= '0;
         end
      end else if ((cmd.op == OP_LIFE) && (cmd.step == STEP_LAST)) begin
         if (px_ff == X_MAX) begin
            px_ff <= '0;
            py_ff <= yd;
         end else begin
            px_ff <= xr;
         end
      end else if ((cmd.op == OP_MARG) && (cmd.step == STEP_LAST)) begin
         if (col_wrap) begin
            px_ff <= par_ff ? X_MAX : '0;
            py_ff <= next_row[YW-1:0];
         end else begin
            px_ff <= next_col[XW-1:0];
         end
      end

      if (cmd.op == OP_LIFE) begin
         if (cmd.step == '0) begin
            cnt_ff <= 4'd0;
         end else if (cmd.step == STEP_SELF_DATA) begin
            self_ff <= s_rdata[0];
         end else begin
            cnt_ff <= life_sum;
         end
      end

      if ((cmd.op == OP_MARG) && (cmd.step != '0) && (cmd.step < STEP_MARG_SUM)) begin
         v_ff[2'(cmd.step - 4'd1)] <= g_rdata;
      end
      if ((cmd.op == OP_MARG) && (cmd.step == STEP_MARG_SUM)) begin
         flip_ff <= (blk_sum >= 10'd1) && (blk_sum <= 10'd3);
      end

      if (cmd.finish) begin
         rsp_ff.read_value      <= (cmd.op == OP_RD_DONE) ? g_rdata : 8'd0;
         rsp_ff.finished_action <= act_ff;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   tcag_ram #(.DATA_W(8), .DEPTH(CELL_COUNT)) u_grid (
      .clock (clock),
      .we    (g_we),
      .waddr (g_waddr),
      .wdata (g_wdata),
      .raddr (g_raddr),
      .rdata (g_rdata)
   );

   tcag_ram #(.DATA_W(8), .DEPTH(CELL_COUNT)) u_snap (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

endmodule

// ===== design/tcag_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcag_ctrl
// Controller: sequences clear, access and generation passes over the datapath.
// ----------------------------------------------------------------------------
module tcag_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              action,
   input  tcag_pkg::dp_status_type sts,
   output logic                    busy,
   output tcag_pkg::ctrl_cmd_type  cmd
);
   import tcag_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_WRITE    = 3'd2;
   localparam logic [2:0] S_RD_ISSUE = 3'd3;
   localparam logic [2:0] S_RD_DONE  = 3'd4;
   localparam logic [2:0] S_COPY     = 3'd5;
   localparam logic [2:0] S_LIFE     = 3'd6;
   localparam logic [2:0] S_MARG     = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              finish;
   logic [2:0]        op;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      finish   = 1'b0;
      op       = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            op = OP_CLEAR;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            step_in = '0;
            if (start) begin
               case (action)
                  ACT_WRITE: state_in = S_WRITE;
                  ACT_READ:  state_in = S_RD_ISSUE;
                  ACT_LIFE:  state_in = S_COPY;
                  default:   state_in = S_MARG;
               endcase
            end
         end
         S_WRITE: begin
            op       = OP_WRITE;
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         S_RD_ISSUE: begin
            op       = OP_RD_ISSUE;
            state_in = S_RD_DONE;
         end
         S_RD_DONE: begin
            op       = OP_RD_DONE;
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         S_COPY: begin
            op = OP_COPY;
            if (sts.copy_done) begin
               state_in = S_LIFE;
               step_in  = '0;
            end
         end
         S_LIFE, S_MARG: begin
            op = (state_ff == S_LIFE) ? OP_LIFE : OP_MARG;
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               if ((state_ff == S_LIFE) ? sts.cell_last : sts.block_last) begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign cmd.load   = start && !busy;
   assign cmd.op     = op;
   assign cmd.step   = step_ff;
   assign cmd.finish = finish;

endmodule

// ===== design/toroidal_cellular_automaton_grid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_cellular_automaton_grid
// Toroidal grid of byte cells with cell access, life and block-rule passes.
// ----------------------------------------------------------------------------
// Using the block: after reset the grid memory is swept to zero, one cell per
// cycle with busy held high.
// Raise start with a request while busy is low; the item is taken at that
// edge. Exactly one result comes back per item as a one-cycle strobe on
// rsp_valid with rsp alongside; the receiver cannot stall, so capture it then.
// Between the accepting edge and the result strobe, a write updates one cell,
// a read issues and then completes a grid read, a life generation copies the
// grid into a snapshot memory and then, per cell, makes nine snapshot reads
// through the single read port plus the write back, and a margolus step makes,
// per block, four grid reads, a sum, then four writes when the block flips.
// A new item may be started in the cycle the previous result is shown.
// ----------------------------------------------------------------------------
module toroidal_cellular_automaton_grid (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcag_pkg::req_type req,
   output logic              rsp_valid,
   output tcag_pkg::rsp_type rsp
);
   import tcag_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // sequence passes and accesses
   tcag_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req.action),
      .sts    (sts),
      .busy   (busy),
      .cmd    (cmd)
   );

   // hold the grid, generate addresses, apply the rules
   tcag_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp),
      .rsp_valid (rsp_valid)
   );

`ifndef SYNTH
   // a result strobe always closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding busy cycle");

   // an accepted item always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // results never come on consecutive cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");
`endif

endmodule

// ===== tb/toroidal_cellular_automaton_grid_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_cellular_automaton_grid_test
// Self-checking bench for the toroidal cell grid.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a falling-edge driver. Every accepted item is
// applied to a local copy of the grid, which yields the expected result. A
// rising-edge monitor compares each strobed result with the oldest expected
// result. Directed items cover extreme coordinates and all four actions.
// Random traffic follows: mostly writes and reads with small values, so that
// block passes find work, plus occasional life and block passes.
// ----------------------------------------------------------------------------
module toroidal_cellular_automaton_grid_test;
   import tcag_pkg::*;

   localparam int  HALF_PERIOD = 6;
   localparam int  RESET_CYCLES = 9;
   localparam int  RANDOM_ITEMS = 120;
   // Life passes are the longest items; a few dozen of them still fit easily.
   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam int  DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp;

   req_type pending_items[$];
   rsp_type expected_results[$];
   logic [7:0] grid_model[CELL_COUNT];

   bit     item_taken = 1'b0;
   bit     quiet_stretch = 1'b0;
   bit     stimulus_done = 1'b0;
   int     failures = 0;
   int     action_count[4];
   longint cycle_count = 0;

   toroidal_cellular_automaton_grid u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp(rsp)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Reduce a signed byte into 0..size-1.
   function automatic int fold_coord(logic signed [7:0] v, int size);
      int r;
      r = int'(v) % size;
      if (r < 0) begin
         r += size;
      end
      return r;
   endfunction

   function automatic int cell_index(int x, int y);
      return y * COLS + x;
   endfunction

   // One B3/S23 generation from a snapshot of the old grid.
   function automatic void run_life_generation();
      logic [7:0] old_grid[CELL_COUNT];
      int live;
      logic self_bit;
      old_grid = grid_model;
      for (int y = 0; y < ROWS; y++) begin
         for (int x = 0; x < COLS; x++) begin
            live = 0;
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  if (dx != 0 || dy != 0) begin
                     live += old_grid[cell_index((x + dx + COLS) % COLS,
                                                 (y + dy + ROWS) % ROWS)][0];
                  end
               end
            end
            self_bit = old_grid[cell_index(x, y)][0];
            grid_model[cell_index(x, y)] =
               {6'd0, self_bit, ((live | int'(self_bit)) == 3) ? 1'b1 : 1'b0};
         end
      end
   endfunction

   // Flip one 2x2 block in place when its byte sum is 1 to 3.
   function automatic void flip_block(int xa, int xb, int ya, int yb);
      int sum;
      sum = grid_model[cell_index(xa, ya)] + grid_model[cell_index(xb, ya)]
          + grid_model[cell_index(xa, yb)] + grid_model[cell_index(xb, yb)];
      if (sum >= 1 && sum <= 3) begin
         grid_model[cell_index(xa, ya)] = 8'd1 - grid_model[cell_index(xa, ya)];
         grid_model[cell_index(xb, ya)] = 8'd1 - grid_model[cell_index(xb, ya)];
         grid_model[cell_index(xa, yb)] = 8'd1 - grid_model[cell_index(xa, yb)];
         grid_model[cell_index(xb, yb)] = 8'd1 - grid_model[cell_index(xb, yb)];
      end
   endfunction

   // Rows ascending after the wrapping row; within a row the wrapping block comes first.
   function automatic void flip_block_row(int p, int ya, int yb);
      if (p != 0) begin
         flip_block(COLS - 1, 0, ya, yb);
      end
      for (int x = p; x < COLS - 1; x += 2) begin
         flip_block(x, x + 1, ya, yb);
      end
   endfunction

   function automatic void run_margolus_pass(int p);
      if (p != 0) begin
         flip_block_row(p, ROWS - 1, 0);
      end
      for (int y = p; y < ROWS - 1; y += 2) begin
         flip_block_row(p, y, y + 1);
      end
   endfunction

   // Apply one accepted item to the grid copy and return its result.
   function automatic rsp_type predict_result(req_type item);
      rsp_type r;
      int idx;
      r = '0;
      r.finished_action = item.action;
      idx = cell_index(fold_coord(item.x_coord, COLS),
                       fold_coord(item.y_coord, ROWS));
      case (item.action)
         ACT_WRITE: begin
            grid_model[idx] = item.write_value;
         end
         ACT_READ: begin
            r.read_value = grid_model[idx];
         end
         ACT_LIFE: begin
            run_life_generation();
         end
         default: begin
            run_margolus_pass(int'(item.block_parity));
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_item(logic [1:0] act, int x, int y, int v, bit p);
      req_type it;
      it.action       = act;
      it.x_coord      = 8'(x);
      it.y_coord      = 8'(y);
      it.write_value  = 8'(v);
      it.block_parity = p;
      return it;
   endfunction

   // Driver: present items at the falling edge, hold until taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !item_taken) begin
            // hold the current item
         end else if (pending_items.size() != 0 &&
                      (quiet_stretch || $urandom_range(99) >= 13)) begin
            start <= 1'b1;
            req   <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
            req   <= make_item(2'($urandom_range(3)), $urandom_range(255),
                               $urandom_range(255), $urandom_range(255), 1'($urandom));
         end
      end
   end

   // Acceptance and result check at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      item_taken = !reset && start && !busy;
      if (item_taken) begin
         expected_results.push_back(predict_result(req));
         action_count[req.action]++;
      end
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, actual read_value=%0h finished_action=%0d",
                     $time, rsp.read_value, rsp.finished_action);
            failures++;
         end else begin
            if (rsp.read_value !== expected_results[0].read_value) begin
               $display("%0t: read_value mismatch, expected=%0h actual=%0h",
                        $time, expected_results[0].read_value, rsp.read_value);
               failures++;
            end
            if (rsp.finished_action !== expected_results[0].finished_action) begin
               $display("%0t: finished_action mismatch, expected=%0d actual=%0d",
                        $time, expected_results[0].finished_action, rsp.finished_action);
               failures++;
            end
            void'(expected_results.pop_front());
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_results.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int roll;
      for (int i = 0; i < CELL_COUNT; i++) begin
         grid_model[i] = 8'd0;
      end
      for (int i = 0; i < 4; i++) begin
         action_count[i] = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extreme coordinates, read back, small patterns, every action.
      pending_items.push_back(make_item(ACT_READ, 5, 5, 0, 0));
      pending_items.push_back(make_item(ACT_WRITE, -64, -64, 255, 1));
      pending_items.push_back(make_item(ACT_WRITE, 127, 127, 8'h80, 0));
      pending_items.push_back(make_item(ACT_WRITE, -1, 0, 1, 0));
      pending_items.push_back(make_item(ACT_READ, 0, 0, 0, 1));
      pending_items.push_back(make_item(ACT_READ, 63, 63, 0, 0));
      pending_items.push_back(make_item(ACT_READ, 63, 0, 0, 0));
      // glider near the wrapped corner, plus a blinker
      pending_items.push_back(make_item(ACT_WRITE, 1, 62, 1, 0));
      pending_items.push_back(make_item(ACT_WRITE, 2, 63, 1, 0));
      pending_items.push_back(make_item(ACT_WRITE, 0, 0, 1, 0));
      pending_items.push_back(make_item(ACT_WRITE, 1, 0, 3, 0));
      pending_items.push_back(make_item(ACT_WRITE, 2, 0, 1, 0));
      pending_items.push_back(make_item(ACT_WRITE, 30, 20, 1, 0));
      pending_items.push_back(make_item(ACT_WRITE, 31, 20, 1, 0));
      pending_items.push_back(make_item(ACT_WRITE, 32, 20, 1, 0));
      pending_items.push_back(make_item(ACT_LIFE, 0, 0, 0, 1));
      pending_items.push_back(make_item(ACT_READ, 31, 21, 0, 0));
      pending_items.push_back(make_item(ACT_READ, 1, 0, 0, 0));
      pending_items.push_back(make_item(ACT_MARGOLUS, 0, 0, 0, 0));
      pending_items.push_back(make_item(ACT_READ, 31, 20, 0, 0));
      pending_items.push_back(make_item(ACT_MARGOLUS, 0, 0, 0, 1));
      pending_items.push_back(make_item(ACT_READ, 0, 63, 0, 0));
      pending_items.push_back(make_item(ACT_READ, -64, 127, 0, 1));

      // Random: mostly cell traffic, with rare whole-grid passes.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            pending_items.push_back(make_item(ACT_LIFE, $urandom_range(255),
                                              $urandom_range(255), $urandom_range(255),
                                              1'($urandom)));
         end else if (roll < 8) begin
            pending_items.push_back(make_item(ACT_MARGOLUS, $urandom_range(255),
                                              $urandom_range(255), $urandom_range(255),
                                              1'($urandom)));
         end else if (roll < 55) begin
            pending_items.push_back(make_item(ACT_WRITE, int'($urandom_range(191)) - 64,
                                              int'($urandom_range(191)) - 64,
                                              ($urandom_range(3) == 0) ?
                                                 $urandom_range(255) : $urandom_range(3),
                                              1'($urandom)));
         end else begin
            pending_items.push_back(make_item(ACT_READ, int'($urandom_range(191)) - 64,
                                              int'($urandom_range(191)) - 64,
                                              $urandom_range(255), 1'($urandom)));
         end
      end

      // Drop idling for a stretch in the middle of the random part.
      wait (pending_items.size() < 100);
      quiet_stretch = 1'b1;
      wait (pending_items.size() < 50);
      quiet_stretch = 1'b0;
      wait (pending_items.size() == 0);
      // hold until the last presented item has been taken
      do begin
         @(negedge clock);
      end while (start && !item_taken);
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d reads, %0d life passes, %0d block passes",
               action_count[0], action_count[1], action_count[2], action_count[3]);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
